### hw/rtl/fupd_pkg.sv
package fupd_pkg;

    localparam int HEAD_LEN = 6;

    // "file:/" packed with the first character in the top byte
    localparam logic [8*HEAD_LEN-1:0] FILE_PREFIX = "file:/";

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SLASH   = 8'h2F;

    // escape decoder step
    localparam logic [1:0] ESC_NONE = 2'd0;
    localparam logic [1:0] ESC_HIGH = 2'd1;
    localparam logic [1:0] ESC_LOW  = 2'd2;

    // done status
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_SHORT  = 2'd1;
    localparam logic [1:0] ST_BADESC = 2'd2;
    localparam logic [1:0] ST_AUTH   = 2'd3;

    typedef struct packed {
        logic       ok;
        logic       emit;
        logic [7:0] ch;
        logic [1:0] esc;
        logic [3:0] nib;
    } t_feed_res;

    // bit 4 set means not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b0, c[3:0]};
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            v = {1'b0, c[3:0] + 4'd9};
        end else begin
            v = 5'h10;
        end
        return v;
    endfunction

endpackage

### hw/rtl/file_uri_percent_decoder_unit.sv
// channel  | handshake                    | payload
// ---------+------------------------------+-----------------------------------------
// in       | i_in_valid / o_in_ready      | i_ch, i_is_last
// out      | o_out_valid / i_out_ready    | o_out_char, o_char_valid, o_done_res, o_status
//
// One request is taken per pass of the sequencer. A head byte passes the head check when it
// is last or follows the sixth, a body byte passes the decode state, and a last byte ends
// in the finish state. The head flush, on the request that ends the head, feeds the held
// bytes (up to six) through the one escape decoder, one per cycle while output has room.
// Each emitted result waits for the single output register; the sequencer holds while it
// is full and not taken. Reset is synchronous, active low.
module file_uri_percent_decoder_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_ch,
    input  logic       i_is_last,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_char,
    output logic       o_char_valid,
    output logic       o_done_res,
    output logic [1:0] o_status
);
    import fupd_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_HEADCHK = 3'd1;
    localparam logic [2:0] S_REPLAY  = 3'd2;
    localparam logic [2:0] S_SLASH   = 3'd3;
    localparam logic [2:0] S_CUR     = 3'd4;
    localparam logic [2:0] S_FIN     = 3'd5;

    localparam logic [1:0] PH_HEAD    = 2'd0;
    localparam logic [1:0] PH_AUTH    = 2'd1;
    localparam logic [1:0] PH_BODY    = 2'd2;
    localparam logic [1:0] PH_SWALLOW = 2'd3;

    localparam logic [2:0] HEAD_CNT = 3'(HEAD_LEN);

    logic [2:0] r_state, n_state;
    logic [2:0] r_cnt,   n_cnt;
    logic [1:0] r_phase, n_phase;
    logic [1:0] r_esc,   n_esc;
    logic [3:0] r_nib,   n_nib;
    logic [1:0] r_err,   n_err;
    logic [7:0] r_c,     n_c;
    logic       r_last,  n_last;
    logic       r_long,  n_long;
    logic [2:0] r_idx,   n_idx;
    logic [1:0] r_fin,   n_fin;
    logic [7:0] r_buf [HEAD_LEN];

    logic       r_o_valid;
    logic [7:0] r_o_char;
    logic       r_o_cv;
    logic       r_o_done;
    logic [1:0] r_o_st;

    logic       w_accept;
    logic       w_buf_we;
    logic       w_can_push;
    logic       w_match;
    logic [7:0] w_feed_byte;
    t_feed_res  w_f;
    logic       w_push;
    logic [7:0] w_push_char;
    logic       w_push_cv;
    logic       w_push_done;
    logic [1:0] w_push_st;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_can_push = !r_o_valid || i_out_ready;
    assign w_buf_we   = w_accept && (r_phase == PH_HEAD) && (r_cnt < HEAD_CNT);
    assign w_match    = ({r_buf[0], r_buf[1], r_buf[2], r_buf[3], r_buf[4], r_buf[5]}
                         == FILE_PREFIX);
    assign w_feed_byte = (r_state == S_REPLAY) ? r_buf[r_idx] : r_c;

    fupd_feed u_feed (
        .i_byte (w_feed_byte),
        .i_esc  (r_esc),
        .i_nib  (r_nib),
        .o_res  (w_f)
    );

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_phase     = r_phase;
        n_esc       = r_esc;
        n_nib       = r_nib;
        n_err       = r_err;
        n_c         = r_c;
        n_last      = r_last;
        n_long      = r_long;
        n_idx       = r_idx;
        n_fin       = r_fin;
        w_push      = 1'b0;
        w_push_char = w_f.ch;
        w_push_cv   = 1'b1;
        w_push_done = 1'b0;
        w_push_st   = ST_OK;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_c    = i_ch;
                    n_last = i_is_last;
                    case (r_phase)
                        PH_AUTH: begin
                            if (i_ch == CH_SLASH) begin
                                n_phase = PH_BODY;
                            end
                            if (i_is_last) begin
                                n_fin   = (i_ch == CH_SLASH) ? ST_OK : ST_AUTH;
                                n_state = S_FIN;
                            end
                        end
                        PH_BODY: begin
                            n_state = S_CUR;
                        end
                        PH_SWALLOW: begin
                            if (i_is_last) begin
                                n_fin   = r_err;
                                n_state = S_FIN;
                            end
                        end
                        default: begin
                            if (r_cnt < HEAD_CNT) begin
                                n_cnt  = r_cnt + 3'd1;
                                n_long = 1'b0;
                                if (i_is_last) begin
                                    n_state = S_HEADCHK;
                                end
                            end else begin
                                n_long  = 1'b1;
                                n_state = S_HEADCHK;
                            end
                        end
                    endcase
                end
            end
            S_HEADCHK: begin
                if (!r_long) begin
                    if (r_cnt == HEAD_CNT && w_match) begin
                        n_fin   = ST_SHORT;
                        n_state = S_FIN;
                    end else begin
                        n_esc   = ESC_NONE;
                        n_idx   = 3'd0;
                        n_state = S_REPLAY;
                    end
                end else if (w_match) begin
                    n_state = S_SLASH;
                end else begin
                    n_phase = PH_BODY;
                    n_esc   = ESC_NONE;
                    n_idx   = 3'd0;
                    n_state = S_REPLAY;
                end
            end
            S_REPLAY: begin
                if (!w_f.emit || w_can_push) begin
                    w_push = w_f.emit;
                    if (!w_f.ok) begin
                        if (!r_long) begin
                            n_fin   = ST_SHORT;
                            n_state = S_FIN;
                        end else if (r_last) begin
                            n_fin   = ST_BADESC;
                            n_state = S_FIN;
                        end else begin
                            n_phase = PH_SWALLOW;
                            n_err   = ST_BADESC;
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_esc = w_f.esc;
                        n_nib = w_f.nib;
                        if (r_idx == r_cnt - 3'd1) begin
                            if (!r_long) begin
                                n_fin   = (w_f.esc != ESC_NONE) ? ST_SHORT : ST_OK;
                                n_state = S_FIN;
                            end else begin
                                n_state = S_CUR;
                            end
                        end else begin
                            n_idx = r_idx + 3'd1;
                        end
                    end
                end
            end
            S_SLASH: begin
                if (w_can_push) begin
                    w_push      = 1'b1;
                    w_push_char = CH_SLASH;
                    if (r_c == CH_SLASH) begin
                        n_phase = PH_AUTH;
                        if (r_last) begin
                            n_fin   = ST_AUTH;
                            n_state = S_FIN;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_phase = PH_BODY;
                        n_state = S_CUR;
                    end
                end
            end
            S_CUR: begin
                if (!w_f.emit || w_can_push) begin
                    w_push = w_f.emit;
                    if (!w_f.ok) begin
                        if (r_last) begin
                            n_fin   = ST_BADESC;
                            n_state = S_FIN;
                        end else begin
                            n_phase = PH_SWALLOW;
                            n_err   = ST_BADESC;
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_esc = w_f.esc;
                        n_nib = w_f.nib;
                        if (r_last) begin
                            n_fin   = (w_f.esc != ESC_NONE) ? ST_BADESC : ST_OK;
                            n_state = S_FIN;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            S_FIN: begin
                if (w_can_push) begin
                    w_push      = 1'b1;
                    w_push_char = 8'd0;
                    w_push_cv   = 1'b0;
                    w_push_done = 1'b1;
                    w_push_st   = r_fin;
                    // drop back to the reset state for the next string
                    n_cnt       = 3'd0;
                    n_phase     = PH_HEAD;
                    n_esc       = ESC_NONE;
                    n_nib       = 4'd0;
                    n_err       = ST_OK;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= 3'd0;
            r_phase   <= PH_HEAD;
            r_esc     <= ESC_NONE;
            r_nib     <= 4'd0;
            r_err     <= ST_OK;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_phase   <= n_phase;
            r_esc     <= n_esc;
            r_nib     <= n_nib;
            r_err     <= n_err;
            r_o_valid <= w_push || (r_o_valid && !i_out_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        r_c    <= n_c;
        r_last <= n_last;
        r_long <= n_long;
        r_idx  <= n_idx;
        r_fin  <= n_fin;
        if (w_buf_we) begin
            r_buf[r_cnt] <= i_ch;
        end
        if (w_push) begin
            r_o_char <= w_push_char;
            r_o_cv   <= w_push_cv;
            r_o_done <= w_push_done;
            r_o_st   <= w_push_st;
        end
    end

    assign o_out_valid  = r_o_valid;
    assign o_out_char   = r_o_char;
    assign o_char_valid = r_o_cv;
    assign o_done_res   = r_o_done;
    assign o_status     = r_o_st;

endmodule

### hw/rtl/fupd_feed.sv
module fupd_feed (
    input  logic [7:0]          i_byte,
    input  logic [1:0]          i_esc,
    input  logic [3:0]          i_nib,
    output fupd_pkg::t_feed_res o_res
);
    import fupd_pkg::*;

    logic [4:0] w_hex;

    assign w_hex = hex_value(i_byte);

    always_comb begin
        o_res.ok   = 1'b1;
        o_res.emit = 1'b0;
        o_res.ch   = i_byte;
        o_res.esc  = i_esc;
        o_res.nib  = i_nib;
        case (i_esc)
            ESC_HIGH: begin
                if (w_hex[4]) begin
                    o_res.ok = 1'b0;
                end else begin
                    o_res.nib = w_hex[3:0];
                    o_res.esc = ESC_LOW;
                end
            end
            ESC_LOW: begin
                if (w_hex[4]) begin
                    o_res.ok = 1'b0;
                end else begin
                    o_res.emit = 1'b1;
                    o_res.ch   = {i_nib, w_hex[3:0]};
                    o_res.esc  = ESC_NONE;
                end
            end
            default: begin
                if (i_byte == CH_PERCENT) begin
                    o_res.esc = ESC_HIGH;
                end else begin
                    o_res.emit = 1'b1;
                    o_res.esc  = ESC_NONE;
                end
            end
        endcase
    end

endmodule
